// File: rtl/core/ilid_pkg.sv
// Package for the indexed list insert/delete unit: command and result
// structs, opcode and status codes, and the per-cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package ilid_pkg;

  // Widest cell index the unit supports (up to 1024 cells)
  localparam int unsigned POS_W = 10;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_AT   = 3'd3,
    OP_DELETE   = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What every cell does on this transfer
  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_DELETE = 2'd2
  } shift_e;

  typedef struct packed {
    logic [2:0]          opcode;
    logic signed [11:0]  position;
    logic signed [31:0]  item_value;
  } ilid_cmd_t;

  typedef struct packed {
    logic signed [31:0]  read_value;
    logic [1:0]          status;
    logic [10:0]         entry_count;
  } ilid_res_t;

  typedef struct packed {
    shift_e              mode;
    logic [POS_W-1:0]    target;
    logic signed [31:0]  value;
  } ilid_ctrl_t;

endpackage

// File: rtl/core/ilid_cell.sv
// One storage cell of the list chain: holds a single entry and takes its
// neighbour's value on an insert or delete shift. Depends on ilid_pkg.
`timescale 1ns / 1ps

module ilid_cell import ilid_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  ilid_ctrl_t         ctrl_i,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  output logic signed [31:0] value_o,
  output logic signed [31:0] rd_o
);

  localparam logic [POS_W-1:0] MyIdx = POS_W'(IDX);

  logic signed [31:0] value_q, value_d;

  // Next entry: hold, take from the left (insert) or from the right (delete)
  always_comb begin
    value_d = value_q;
    case (ctrl_i.mode)
      SH_INSERT: begin
        if (MyIdx == ctrl_i.target) begin
          value_d = ctrl_i.value;
        end else if (MyIdx > ctrl_i.target) begin
          value_d = left_i;
        end
      end
      SH_DELETE: begin
        if (MyIdx >= ctrl_i.target) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // Drive the read bus only when addressed
  assign rd_o = (MyIdx == ctrl_i.target) ? value_q : 32'sd0;

endmodule

// File: rtl/core/indexed_list_insert_delete_unit.sv
// Indexed list insert/delete unit, top level: command decode, entry
// count, a chain of ilid_cell and the result register. Depends on ilid_pkg and ilid_cell.
//
// Usage:
//   A command transfers on a rising edge with start high and busy low.
//   busy is never raised: one command is taken every cycle.
//   Commands read, insert at head, tail or index, or delete at index.
//   All cells shift at once on the accepting edge, so every command
//   completes on that edge.
//   The result (read value, status, count after the command) is registered
//   on res_o, marked by done_o high for a single cycle, in the cycle after
//   the command transfer; throughput 1 command per cycle.
//   The read value is gathered by an AND-OR bus across all CAPACITY cells.
//   The receiver cannot stall; a result is taken in the cycle it is shown.
//   Reset clears the count and done_o; cell contents are unknown until
//   written, but only entries below the count are ever read.
`timescale 1ns / 1ps

module indexed_list_insert_delete_unit import ilid_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  ilid_cmd_t cmd_i,
  output logic      done_o,
  output ilid_res_t res_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q;
  ilid_res_t         res_q, res_d;
  ilid_ctrl_t        ctrl;
  logic              accept;
  logic              pos_neg;
  logic [11:0]       pos_u;
  logic [11:0]       cnt_ext;
  logic              full;
  logic              rd_ok;
  logic signed [31:0] rd_bus;

  logic signed [31:0] cell_val [CAPACITY];
  logic signed [31:0] cell_rd  [CAPACITY];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pos_neg = cmd_i.position[11];
  assign pos_u   = {1'b0, cmd_i.position[10:0]};
  assign cnt_ext = 12'(cnt_q);
  assign full    = (cnt_q == CntW'(CAPACITY));

  // Command decode: cell control, status and next count
  always_comb begin
    ctrl.mode   = SH_HOLD;
    ctrl.target = POS_W'(cmd_i.position[10:0]);
    ctrl.value  = cmd_i.item_value;
    cnt_d       = cnt_q;
    rd_ok       = 1'b0;
    res_d.read_value = 32'sd0;
    res_d.status     = ST_DONE;
    unique case (cmd_i.opcode)
      OP_READ: begin
        if (pos_neg || pos_u >= cnt_ext) begin
          res_d.read_value = -32'sd1;
          res_d.status     = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
        if (cmd_i.opcode == OP_INS_HEAD || (cmd_i.opcode == OP_INS_AT && pos_neg)) begin
          ctrl.target = '0;
        end else if (cmd_i.opcode == OP_INS_TAIL) begin
          ctrl.target = POS_W'(cnt_q);
        end
        if (cmd_i.opcode == OP_INS_AT && !pos_neg && pos_u > cnt_ext) begin
          res_d.status = ST_RANGE;
        end else if (full) begin
          res_d.status = ST_FULL;
        end else begin
          ctrl.mode = SH_INSERT;
          cnt_d     = cnt_q + CntW'(1);
        end
      end
      OP_DELETE: begin
        if (pos_neg || pos_u >= cnt_ext) begin
          res_d.status = ST_RANGE;
        end else begin
          ctrl.mode = SH_DELETE;
          cnt_d     = cnt_q - CntW'(1);
        end
      end
      default: res_d.status = ST_RANGE;
    endcase
    if (!accept) begin
      ctrl.mode = SH_HOLD;
      cnt_d     = cnt_q;
    end
    if (rd_ok) begin
      res_d.read_value = rd_bus;
    end
    res_d.entry_count = 11'(cnt_d);
  end

  // Chain of cells, head at index 0
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_v, right_v;
    if (g == 0) begin : g_head
      assign left_v = 32'sd0;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_v = cell_val[g];
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end
    ilid_cell #(.IDX(g)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (cell_val[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // Read bus: only the addressed cell drives non-zero
  always_comb begin
    rd_bus = 32'sd0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // Count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Every accepted command gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("command transfer without result");

  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.entry_count <= 11'(CAPACITY))
    else $error("entry count above capacity");

  // A full rejection only happens with the store at capacity
  a_full_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_FULL) |-> res_o.entry_count == 11'(CAPACITY))
    else $error("full status below capacity");

  // A rejected or ignored command leaves the count unchanged
  a_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != ST_DONE) |-> res_o.entry_count == 11'($past(cnt_q)))
    else $error("count changed by ignored command");

endmodule

// File: verif/indexed_list_insert_delete_unit_tb.sv
// Self-checking testbench for indexed_list_insert_delete_unit: drives list
// commands with random gaps and checks every result against a local list model.
// Depends on ilid_pkg and the unit itself, and through the unit on ilid_cell.
`timescale 1ns / 1ps

module indexed_list_insert_delete_unit_tb;
  import ilid_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int CLK_HALF = 6;
  // Opcodes the unit does not define
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  // Generous bound on how long the result queue may take to empty
  localparam int DRAIN_LIMIT = 1000;
  // Commands to transfer over the whole run, directed phases included
  localparam int ITEM_TARGET = 1550;

  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} bias_e;

  // List model plus queue of awaited results
  class list_scoreboard #(int DEPTH = 64);
    logic signed [31:0] cells [DEPTH];
    int entry_total;
    ilid_res_t awaited_results [$];
    int error_count;
    int noted_count;
    int checked_count;
    int full_rejects;
    int peak_fill;

    function new();
      entry_total   = 0;
      error_count   = 0;
      noted_count   = 0;
      checked_count = 0;
      full_rejects  = 0;
      peak_fill     = 0;
    endfunction

    // Open a gap at slot and write v there, unless the list is full
    function logic [1:0] place_value(int slot, logic signed [31:0] v);
      if (entry_total >= DEPTH) begin
        full_rejects++;
        return ST_FULL;
      end
      for (int i = entry_total; i > slot; i--) cells[i] = cells[i-1];
      cells[slot] = v;
      entry_total++;
      if (entry_total > peak_fill) peak_fill = entry_total;
      return ST_DONE;
    endfunction

    function ilid_res_t predict_list_op(ilid_cmd_t c);
      ilid_res_t r;
      int pos;
      logic [1:0] st;
      logic signed [31:0] rd;
      pos = c.position;
      rd  = '0;
      st  = ST_DONE;
      case (c.opcode)
        OP_READ: begin
          if (pos < 0 || pos >= entry_total) begin
            rd = -32'sd1;
            st = ST_RANGE;
          end else begin
            rd = cells[pos];
          end
        end
        OP_INS_HEAD: st = place_value(0, c.item_value);
        OP_INS_TAIL: st = place_value(entry_total, c.item_value);
        OP_INS_AT: begin
          // range check takes priority over the full check
          if (pos < 0) st = place_value(0, c.item_value);
          else if (pos > entry_total) st = ST_RANGE;
          else st = place_value(pos, c.item_value);
        end
        OP_DELETE: begin
          if (pos < 0 || pos >= entry_total) begin
            st = ST_RANGE;
          end else begin
            for (int i = pos; i + 1 < entry_total; i++) cells[i] = cells[i+1];
            entry_total--;
          end
        end
        default: st = ST_RANGE;
      endcase
      r.read_value  = rd;
      r.status      = st;
      r.entry_count = 11'(entry_total);
      return r;
    endfunction

    function void note_command(ilid_cmd_t c);
      noted_count++;
      awaited_results.push_back(predict_list_op(c));
    endfunction

    task report_mismatch(string what, longint got, longint want);
      if (error_count < 200)
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
    endtask

    task check_result(ilid_res_t r);
      ilid_res_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result (count)", r.entry_count, -1);
      end else begin
        want = awaited_results.pop_front();
        checked_count++;
        if (r.read_value !== want.read_value)
          report_mismatch("read_value", r.read_value, want.read_value);
        if (r.status !== want.status)
          report_mismatch("status", r.status, want.status);
        if (r.entry_count !== want.entry_count)
          report_mismatch("entry_count", r.entry_count, want.entry_count);
      end
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  ilid_cmd_t cmd_i;
  logic      done_o;
  ilid_res_t res_o;

  list_scoreboard #(CAPACITY) sb;
  int  burst_left;
  bit  timed_out;

  indexed_list_insert_delete_unit #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // Monitor: the result shown now belongs to an earlier transfer, so check first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(res_o);
      if (start && !busy) sb.note_command(cmd_i);
    end
  end

  function automatic ilid_cmd_t make_cmd(logic [2:0] op, int pos, logic signed [31:0] v);
    ilid_cmd_t c;
    c.opcode     = op;
    c.position   = 12'(pos);
    c.item_value = v;
    return c;
  endfunction

  function automatic logic signed [31:0] random_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly sensible indices around the current fill, some negative or wild
  function automatic int random_position();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    n   = sb.entry_total;
    if (sel < 70) return $urandom_range(0, n);
    else if (sel < 80) return n + int'($urandom_range(0, 1));
    else if (sel < 90) return -int'($urandom_range(1, 2048));
    else return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic ilid_cmd_t random_cmd(bias_e bias);
    int sel;
    int ins_lim;
    int del_lim;
    logic [2:0] op;
    sel = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL:  begin ins_lim = 55; del_lim = 70; end
      BIAS_DRAIN: begin ins_lim = 20; del_lim = 60; end
      default:    begin ins_lim = 40; del_lim = 70; end
    endcase
    if (sel < ins_lim) begin
      case ($urandom_range(0, 2))
        0:       op = OP_INS_HEAD;
        1:       op = OP_INS_TAIL;
        default: op = OP_INS_AT;
      endcase
    end else if (sel < del_lim) begin
      op = OP_DELETE;
    end else if (sel < 97) begin
      op = OP_READ;
    end else begin
      op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end
    return make_cmd(op, random_position(), random_value());
  endfunction

  // Idle gap: mostly none or short, a few long, with gap-free bursts
  function automatic int pick_gap();
    int sel;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    else if (sel < 88) return $urandom_range(1, 3);
    else return $urandom_range(6, 30);
  endfunction

  // Called at a falling edge; returns at a falling edge
  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Present one command and hold it until the transfer
  task automatic drive_cmd(ilid_cmd_t c);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_cmd(ilid_cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) idle_cycles(gap);
    drive_cmd(c);
  endtask

  // Hold off until every awaited result has been seen
  task automatic wait_for_drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (sb.awaited_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) timed_out = 1'b1;
    repeat (2) @(negedge clk_i);
  endtask

  task automatic run_directed();
    send_cmd(make_cmd(OP_READ, 0, 32'sd5));               // read on empty list
    send_cmd(make_cmd(OP_READ, -1, 32'sd0));
    send_cmd(make_cmd(OP_DELETE, 0, 32'sd0));             // delete on empty list
    send_cmd(make_cmd(OP_INS_AT, 1, 32'sd9));             // index past the end
    send_cmd(make_cmd(OP_INS_AT, -2048, 32'sh7FFF_FFFF)); // negative index goes to head
    send_cmd(make_cmd(OP_INS_HEAD, 2047, 32'sh8000_0000));
    send_cmd(make_cmd(OP_INS_TAIL, -2048, -32'sd1));
    send_cmd(make_cmd(OP_INS_AT, 3, 32'sh1234_5678));     // at the end exactly
    send_cmd(make_cmd(OP_INS_AT, 1, 32'sh5A5A_A5A5));     // middle
    send_cmd(make_cmd(OP_INS_AT, 7, 32'sd1));             // past the end again
    send_cmd(make_cmd(OP_READ, 0, 32'sd0));
    send_cmd(make_cmd(OP_READ, 1, 32'sd0));
    send_cmd(make_cmd(OP_READ, 4, 32'sd0));
    send_cmd(make_cmd(OP_READ, 5, 32'sd0));               // one past the tail
    send_cmd(make_cmd(OP_READ, 2047, 32'sd0));
    send_cmd(make_cmd(OP_READ, -2048, 32'sd0));
    send_cmd(make_cmd(OP_DELETE, -1, 32'sd0));
    send_cmd(make_cmd(OP_DELETE, 2047, 32'sd0));
    send_cmd(make_cmd(OP_DELETE, 0, 32'sd0));
    send_cmd(make_cmd(OP_DELETE, 3, 32'sd0));             // tail entry
    send_cmd(make_cmd(OP_DELETE, 3, 32'sd0));             // now out of range
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_cmd(make_cmd(3'(op), random_position(), random_value()));
  endtask

  // Fill to capacity, then poke every insert form against a full list
  task automatic run_full_list();
    while (sb.entry_total < CAPACITY)
      send_cmd(random_cmd(BIAS_FILL));
    send_cmd(make_cmd(OP_INS_HEAD, 0, random_value()));
    send_cmd(make_cmd(OP_INS_TAIL, 0, random_value()));
    send_cmd(make_cmd(OP_INS_AT, 5, random_value()));
    send_cmd(make_cmd(OP_INS_AT, CAPACITY, random_value()));
    send_cmd(make_cmd(OP_INS_AT, CAPACITY + 1, random_value())); // range beats full
    send_cmd(make_cmd(OP_INS_AT, -3, random_value()));
    send_cmd(make_cmd(OP_READ, CAPACITY - 1, 32'sd0));
    send_cmd(make_cmd(OP_READ, CAPACITY, 32'sd0));
    send_cmd(make_cmd(OP_DELETE, CAPACITY - 1, 32'sd0));
    send_cmd(make_cmd(OP_INS_TAIL, 0, random_value()));
    while (sb.entry_total > 0)
      send_cmd(random_cmd(BIAS_DRAIN));
  endtask

  // Main sequence
  initial begin
    int items_left;
    int seg_len;
    int guard;
    bias_e bias;
    sb         = new();
    burst_left = 0;
    timed_out  = 1'b0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    cmd_i      = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    wait_for_drain();
    run_full_list();
    wait_for_drain();

    // Random phase makes up the rest of the command budget
    items_left = ITEM_TARGET - sb.noted_count;
    bias = BIAS_FILL;
    while (items_left > 0 && !timed_out) begin
      seg_len = $urandom_range(80, 250);
      if (seg_len > items_left) seg_len = items_left;
      repeat (seg_len) send_cmd(random_cmd(bias));
      items_left -= seg_len;
      case (bias)
        BIAS_FILL:  bias = BIAS_MIXED;
        BIAS_MIXED: bias = BIAS_DRAIN;
        default:    bias = BIAS_FILL;
      endcase
      if ($urandom_range(0, 2) == 0) wait_for_drain();
    end

    // End of stimulus: let the last results arrive
    start <= 1'b0;
    guard = 0;
    while (sb.awaited_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) timed_out = 1'b1;
    repeat (4) @(posedge clk_i);

    $display("Summary: %0d commands transferred, %0d results checked, %0d mismatches",
             sb.noted_count, sb.checked_count, sb.error_count);
    $display("Summary: list filled to %0d of %0d entries, %0d inserts refused as full",
             sb.peak_fill, CAPACITY, sb.full_rejects);
    if (sb.error_count == 0 && sb.awaited_results.size() == 0 && !timed_out) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ilid_pkg.sv
rtl/core/ilid_cell.sv
rtl/core/indexed_list_insert_delete_unit.sv
verif/indexed_list_insert_delete_unit_tb.sv
